// ===== hw/rtl/szod_pkg.sv =====
package szod_pkg;

  // Field widths
  localparam int unsigned AngleW   = 8;
  localparam int unsigned RangeW   = 16;
  localparam int unsigned NearestW = 17;
  localparam int unsigned CfgIdxW  = 2;

  // Sweep geometry default
  localparam int unsigned MaxSweepAngleDef = 180;

  // Empty zone marker and register reset values
  localparam logic [RangeW-1:0] EmptyMin         = 16'd7777;
  localparam logic [RangeW-1:0] ThresholdRst     = 16'd15;
  localparam logic [AngleW-1:0] FrontStartRst    = 8'd61;
  localparam logic [AngleW-1:0] LeftStartRst     = 8'd121;
  localparam logic signed [NearestW-1:0] NearestNone = -17'sd1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegThreshold  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrontStart = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLeftStart  = 2'd2;

  typedef enum logic [1:0] {
    HeadForward  = 2'd0,
    HeadRight    = 2'd1,
    HeadLeft     = 2'd2,
    HeadBackward = 2'd3
  } heading_e;

  typedef struct packed {
    logic [RangeW-1:0] threshold;
    logic [AngleW-1:0] front_start;
    logic [AngleW-1:0] left_start;
  } cfg_t;

  typedef struct packed {
    logic [AngleW-1:0] angle;
    logic [RangeW-1:0] range_value;
    logic              sweep_end;
  } item_t;

  typedef struct packed {
    heading_e                    heading;
    logic signed [NearestW-1:0]  nearest;
  } decision_t;

endpackage

// ===== hw/rtl/sweep_zone_obstacle_decision_core.sv =====
// Sweep zone obstacle decision. Takes one range reading per item and keeps
// the smallest nonzero distance in the right, front and left zones (zone
// bounds set by front_start and left_start; angle 0 never counts as right and
// angles above MaxSweepAngle touch no zone). An item with sweep_end set folds
// its reading in, then yields one result: heading 0 forward, 1 right, 2 left,
// 3 backward, with nearest the chosen zone's minimum (-1 for backward); the
// minima then return to 7777. Items are taken one per cycle while none is held
// back; a result passes the input register, then the result register.
// Only a result left waiting at the output holds back a following item with
// sweep_end set. Configuration is written through cfg_we_i/cfg_idx_i/
// cfg_wdata_i and should change only while no item is in flight.
module sweep_zone_obstacle_decision_core #(
  parameter int unsigned MaxSweepAngle = szod_pkg::MaxSweepAngleDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [szod_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [szod_pkg::RangeW-1:0]          cfg_wdata_i,
  // Reading channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [szod_pkg::AngleW-1:0]          angle_i,
  input  logic [szod_pkg::RangeW-1:0]          range_value_i,
  input  logic                                 sweep_end_i,
  // Decision channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           heading_o,
  output logic signed [szod_pkg::NearestW-1:0] nearest_o
);
  import szod_pkg::*;

  cfg_t      cfg_q;
  item_t     item_q;
  logic      item_valid_q;
  logic      item_fire;
  logic      out_valid_q;
  heading_e  heading_q;
  logic signed [NearestW-1:0] nearest_q;
  decision_t decision;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold   <= ThresholdRst;
      cfg_q.front_start <= FrontStartRst;
      cfg_q.left_start  <= LeftStartRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegThreshold:  cfg_q.threshold   <= cfg_wdata_i;
        RegFrontStart: cfg_q.front_start <= cfg_wdata_i[AngleW-1:0];
        RegLeftStart:  cfg_q.left_start  <= cfg_wdata_i[AngleW-1:0];
        default: ;
      endcase
    end
  end

  // The registered item moves on unless it needs a result slot that is full
  assign item_fire  = item_valid_q && (!item_q.sweep_end || !out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || item_fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.angle       <= angle_i;
      item_q.range_value <= range_value_i;
      item_q.sweep_end   <= sweep_end_i;
    end
  end

  szod_zone_tracker #(
    .MaxSweepAngle(MaxSweepAngle)
  ) u_zone_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (item_fire),
    .item_i    (item_q),
    .cfg_i     (cfg_q),
    .decision_o(decision)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_fire && item_q.sweep_end) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_fire && item_q.sweep_end) begin
      heading_q <= decision.heading;
      nearest_q <= decision.nearest;
    end
  end

  assign out_valid_o = out_valid_q;
  assign heading_o   = heading_q;
  assign nearest_o   = nearest_q;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !(item_fire && item_q.sweep_end))
    else $error("pending result overwritten");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && !item_fire |=> item_valid_q && $stable(item_q))
    else $error("stalled item lost or changed");

  a_result_follows_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(item_fire && item_q.sweep_end))
    else $error("result without sweep end");
`endif

endmodule

// ===== hw/rtl/szod_zone_tracker.sv =====
module szod_zone_tracker #(
  parameter int unsigned MaxSweepAngle = szod_pkg::MaxSweepAngleDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  szod_pkg::item_t     item_i,
  input  szod_pkg::cfg_t      cfg_i,
  output szod_pkg::decision_t decision_o
);
  import szod_pkg::*;

  localparam logic [AngleW-1:0] MaxAngle = AngleW'(MaxSweepAngle);

  logic [RangeW-1:0] right_min_q, front_min_q, left_min_q;
  logic [RangeW-1:0] right_min_d, front_min_d, left_min_d;
  logic [RangeW-1:0] right_new, front_new, left_new;
  logic              in_sweep, in_right, in_front, in_left, has_echo;

  // Zone membership, each test on its own
  assign in_sweep = item_i.angle <= MaxAngle;
  assign has_echo = item_i.range_value != '0;
  assign in_right = in_sweep && (item_i.angle != '0) && (item_i.angle < cfg_i.front_start);
  assign in_front = in_sweep && (item_i.angle >= cfg_i.front_start)
                    && (item_i.angle < cfg_i.left_start);
  assign in_left  = in_sweep && (item_i.angle >= cfg_i.left_start);

  // Running minimum fold
  always_comb begin
    right_new = right_min_q;
    front_new = front_min_q;
    left_new  = left_min_q;
    if (in_right && has_echo && item_i.range_value < right_min_q) begin
      right_new = item_i.range_value;
    end
    if (in_front && has_echo && item_i.range_value < front_min_q) begin
      front_new = item_i.range_value;
    end
    if (in_left && has_echo && item_i.range_value < left_min_q) begin
      left_new = item_i.range_value;
    end
  end

  // Heading decision on the folded minima
  always_comb begin
    if (front_new > cfg_i.threshold) begin
      decision_o.heading = HeadForward;
      decision_o.nearest = NearestW'({1'b0, front_new});
    end else if (right_new > cfg_i.threshold && right_new >= left_new) begin
      decision_o.heading = HeadRight;
      decision_o.nearest = NearestW'({1'b0, right_new});
    end else if (left_new > cfg_i.threshold && left_new >= right_new) begin
      decision_o.heading = HeadLeft;
      decision_o.nearest = NearestW'({1'b0, left_new});
    end else begin
      decision_o.heading = HeadBackward;
      decision_o.nearest = NearestNone;
    end
  end

  // Minima return to empty after a decision
  always_comb begin
    right_min_d = right_min_q;
    front_min_d = front_min_q;
    left_min_d  = left_min_q;
    if (fire_i) begin
      if (item_i.sweep_end) begin
        right_min_d = EmptyMin;
        front_min_d = EmptyMin;
        left_min_d  = EmptyMin;
      end else begin
        right_min_d = right_new;
        front_min_d = front_new;
        left_min_d  = left_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_min_q <= EmptyMin;
      front_min_q <= EmptyMin;
      left_min_q  <= EmptyMin;
    end else begin
      right_min_q <= right_min_d;
      front_min_q <= front_min_d;
      left_min_q  <= left_min_d;
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.sweep_end |=>
      right_min_q == EmptyMin && front_min_q == EmptyMin && left_min_q == EmptyMin)
    else $error("minima not cleared after sweep end");

  a_min_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    right_min_q != '0 && front_min_q != '0 && left_min_q != '0)
    else $error("zone minimum holds zero");

  a_min_no_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !item_i.sweep_end |=>
      right_min_q <= $past(right_min_q) && front_min_q <= $past(front_min_q)
      && left_min_q <= $past(left_min_q))
    else $error("zone minimum rose within a sweep");

  a_backward_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (decision_o.heading == HeadBackward) == (decision_o.nearest == NearestNone))
    else $error("backward heading and nearest mismatch");
`endif

endmodule

// ===== verif/sweep_zone_obstacle_decision_core_tb.sv =====
`timescale 1ns / 1ps

module sweep_zone_obstacle_decision_core_tb;
  import szod_pkg::*;

  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned DrainCycles    = 6;
  localparam int unsigned CycleLimit     = 500000;
  localparam int unsigned PhaseItems     = 80;

  // DUT connections
  logic                       clk_i;
  logic                       rst_n;
  logic                       cfg_we;
  logic [CfgIdxW-1:0]         cfg_idx;
  logic [RangeW-1:0]          cfg_wdata;
  logic                       in_valid;
  logic                       in_ready_o;
  logic [AngleW-1:0]          rd_angle;
  logic [RangeW-1:0]          rd_range;
  logic                       rd_end;
  logic                       out_valid_o;
  logic                       out_ready;
  logic [1:0]                 heading_o;
  logic signed [NearestW-1:0] nearest_o;

  // Predictor copy of configuration and zone minima
  logic [RangeW-1:0] cfg_thr;
  logic [AngleW-1:0] cfg_front;
  logic [AngleW-1:0] cfg_left;
  logic [RangeW-1:0] right_near;
  logic [RangeW-1:0] front_near;
  logic [RangeW-1:0] left_near;

  decision_t pending_decisions[$];

  int unsigned mismatch_count   = 0;
  int unsigned readings_taken   = 0;
  int unsigned decisions_seen   = 0;
  int unsigned settings_applied = 0;
  int unsigned cycle_count      = 0;

  // Idle controls shared by the test tasks and the receiver
  bit send_no_idle  = 1'b0;
  bit recv_no_idle  = 1'b0;
  bit long_hold_req = 1'b0;

  sweep_zone_obstacle_decision_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .angle_i       (rd_angle),
    .range_value_i (rd_range),
    .sweep_end_i   (rd_end),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .heading_o     (heading_o),
    .nearest_o     (nearest_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Gap lengths: mostly short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic [RangeW-1:0] fold_min(logic [RangeW-1:0] cur, logic [RangeW-1:0] d);
    if (d != '0 && d < cur) return d;
    return cur;
  endfunction

  // Zone update and heading decision for one accepted reading
  function automatic void predict_reading(logic [AngleW-1:0] a, logic [RangeW-1:0] d,
                                          logic last);
    decision_t want;
    if (a <= MaxSweepAngleDef) begin
      if (a >= 1 && a < cfg_front) right_near = fold_min(right_near, d);
      if (a >= cfg_front && a < cfg_left) front_near = fold_min(front_near, d);
      if (a >= cfg_left) left_near = fold_min(left_near, d);
    end
    if (last) begin
      if (front_near > cfg_thr) begin
        want.heading = HeadForward;
        want.nearest = {1'b0, front_near};
      end else if (right_near > cfg_thr && right_near >= left_near) begin
        want.heading = HeadRight;
        want.nearest = {1'b0, right_near};
      end else if (left_near > cfg_thr && left_near >= right_near) begin
        want.heading = HeadLeft;
        want.nearest = {1'b0, left_near};
      end else begin
        want.heading = HeadBackward;
        want.nearest = NearestNone;
      end
      pending_decisions.push_back(want);
      right_near = EmptyMin;
      front_near = EmptyMin;
      left_near  = EmptyMin;
    end
  endfunction

  // Input monitor: values are stable from the falling edge to the accepting edge
  always @(negedge clk_i) begin
    if (rst_n && in_valid && in_ready_o) begin
      predict_reading(rd_angle, rd_range, rd_end);
      readings_taken++;
    end
  end

  // Result checker
  always @(negedge clk_i) begin : check_decision
    decision_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_decisions.size() == 0) begin
        $error("unexpected decision: heading %0d nearest %0d", heading_o, nearest_o);
        mismatch_count++;
      end else begin
        want = pending_decisions.pop_front();
        decisions_seen++;
        if (heading_o !== want.heading) begin
          $error("heading: expected %0d, actual %0d", want.heading, heading_o);
          mismatch_count++;
        end
        if (nearest_o !== want.nearest) begin
          $error("nearest: expected %0d, actual %0d", want.nearest, nearest_o);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
      end else if (recv_no_idle || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (idle_len()) @(posedge clk_i);
      end
    end
  end

  // Offer one reading and wait until it is taken; valid stays up on return
  task automatic send_reading(logic [AngleW-1:0] a, logic [RangeW-1:0] d, logic last);
    if (!send_no_idle && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rd_angle <= a;
    rd_range <= d;
    rd_end   <= last;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Stop offering and let every reading in flight come out
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [RangeW-1:0] thr, logic [AngleW-1:0] fs,
                                logic [AngleW-1:0] ls);
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_idx   <= RegThreshold;
    cfg_wdata <= thr;
    @(posedge clk_i);
    cfg_idx   <= RegFrontStart;
    cfg_wdata <= {8'h00, fs};
    @(posedge clk_i);
    cfg_idx   <= RegLeftStart;
    cfg_wdata <= {8'h00, ls};
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cfg_thr   = thr;
    cfg_front = fs;
    cfg_left  = ls;
    settings_applied++;
  endtask

  // Distances: zero, near the threshold, small, mid and full range
  function automatic logic [RangeW-1:0] pick_range();
    int t;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return RangeW'($urandom_range(1, 40));
      3, 4: begin
        t = int'(cfg_thr) + int'($urandom_range(0, 4)) - 2;
        if (t < 0) t = 0;
        if (t > 65535) t = 65535;
        return RangeW'(t);
      end
      5, 6: return RangeW'($urandom_range(1, 9000));
      default: return RangeW'($urandom_range(0, 65535));
    endcase
  endfunction

  // Well-formed sweep with random content; a few readings fall beyond the sweep
  task automatic send_sweep(int unsigned len);
    int unsigned start;
    int unsigned step;
    logic [AngleW-1:0] a;
    start = $urandom_range(0, MaxSweepAngleDef);
    step  = $urandom_range(1, 30);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 11) == 0) a = AngleW'($urandom_range(MaxSweepAngleDef + 1, 255));
      else a = AngleW'((start + k * step) % (MaxSweepAngleDef + 1));
      send_reading(a, pick_range(), k == len - 1);
    end
  endtask

  // Reset settings: each heading, empty zones, zone edges, ignored readings
  task automatic test_default_zones();
    send_reading(8'd0, 16'd100, 1'b1);
    send_reading(8'd90, 16'd10, 1'b0);
    send_reading(8'd30, 16'd500, 1'b0);
    send_reading(8'd150, 16'd400, 1'b1);
    send_reading(8'd90, 16'd5, 1'b0);
    send_reading(8'd30, 16'd200, 1'b0);
    send_reading(8'd150, 16'd300, 1'b1);
    // right and left tie; right is checked first
    send_reading(8'd61, 16'd5, 1'b0);
    send_reading(8'd60, 16'd200, 1'b0);
    send_reading(8'd121, 16'd200, 1'b1);
    // nothing clear, front exactly at the threshold
    send_reading(8'd120, 16'd15, 1'b0);
    send_reading(8'd1, 16'd10, 1'b0);
    send_reading(8'd180, 16'd12, 1'b1);
    // no echo, then angle beyond the sweep
    send_reading(8'd90, 16'd0, 1'b1);
    send_reading(8'd255, 16'd1, 1'b1);
    // equal distance leaves the minimum alone
    send_reading(8'd90, 16'd20, 1'b0);
    send_reading(8'd100, 16'd20, 1'b1);
  endtask

  // Extreme thresholds and crossed or collapsed zone bounds
  task automatic test_zone_bounds();
    apply_settings(16'hFFFF, 8'd150, 8'd30);
    send_reading(8'd100, 16'd40, 1'b1);
    apply_settings(16'h0000, 8'd1, 8'd180);
    send_reading(8'd179, 16'd1, 1'b0);
    send_reading(8'd180, 16'd1, 1'b1);
    apply_settings(ThresholdRst, 8'd180, 8'd180);
    send_reading(8'd179, 16'd20, 1'b0);
    send_reading(8'd180, 16'd30, 1'b1);
  endtask

  // Receiver holds off while sweep ends keep coming, so the input stalls
  task automatic test_output_backpressure();
    apply_settings(16'd2000, FrontStartRst, LeftStartRst);
    send_no_idle  = 1'b1;
    long_hold_req = 1'b1;
    for (int i = 0; i < 30; i++)
      send_reading(AngleW'($urandom_range(0, 255)), pick_range(), 1'b1);
    send_no_idle = 1'b0;
  endtask

  // Random phases: mostly sweeps, some stray readings
  task automatic test_random_sweeps();
    int unsigned sent;
    int unsigned len;
    logic [RangeW-1:0] thr;
    logic [AngleW-1:0] fs;
    logic [AngleW-1:0] ls;
    logic [AngleW-1:0] tmp;
    for (int phase = 0; phase < 6; phase++) begin
      thr = ($urandom_range(0, 3) == 0) ? RangeW'($urandom_range(0, 65535))
                                        : RangeW'($urandom_range(0, 9000));
      fs  = AngleW'($urandom_range(1, MaxSweepAngleDef));
      ls  = AngleW'($urandom_range(1, MaxSweepAngleDef));
      if (fs > ls && $urandom_range(0, 3) != 0) begin
        tmp = fs;
        fs  = ls;
        ls  = tmp;
      end
      if (phase == 4) begin
        thr = '0;
        fs  = AngleW'(MaxSweepAngleDef);
        ls  = 8'd1;
      end else if (phase == 5) begin
        thr = '1;
        fs  = 8'd1;
        ls  = AngleW'(MaxSweepAngleDef);
      end
      apply_settings(thr, fs, ls);
      send_no_idle = (phase == 2);
      recv_no_idle = (phase == 2);
      sent = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(0, 4) != 0) begin
          len = $urandom_range(1, 16);
          send_sweep(len);
          sent += len;
        end else begin
          send_reading(AngleW'($urandom_range(0, 255)), pick_range(),
                       $urandom_range(0, 3) == 0);
          sent++;
        end
      end
    end
    send_no_idle = 1'b0;
    recv_no_idle = 1'b0;
  endtask

  // Main sequence
  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= RegThreshold;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    rd_angle  <= '0;
    rd_range  <= '0;
    rd_end    <= 1'b0;
    cfg_thr    = ThresholdRst;
    cfg_front  = FrontStartRst;
    cfg_left   = LeftStartRst;
    right_near = EmptyMin;
    front_near = EmptyMin;
    left_near  = EmptyMin;
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_default_zones();
    test_zone_bounds();
    test_output_backpressure();
    test_random_sweeps();
    drain_pipeline();

    $display("Run covered %0d readings and %0d decisions under %0d register settings,",
             readings_taken, decisions_seen, settings_applied + 1);
    $display("including a long output stall and crossed zone bounds.");
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
